// File: hw/rtl/sha256md_pkg.sv
// sha256md_pkg: shared types, constants and functions of the sha-256 digest block
// round constants, initial hash words, sigma functions, command codes, control structs
// no dependencies
`timescale 1ns / 1ps

package sha256md_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		CMD_ABSORB  = 2'd0,
		CMD_FINISH  = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ACC,
		ST_PAD2,
		ST_EMIT
	} state_t;

	// schedule / block buffer controls
	typedef struct packed {
		logic wr_byte;
		logic pad_first;
		logic pad_second;
		logic shift;
	} sch_ctrl_t;

	// round unit controls
	typedef struct packed {
		logic init;
		logic load;
		logic step;
		logic acc;
	} rnd_ctrl_t;

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t HashIv [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: hw/rtl/sha256md_sched.sv
// sha256md_sched: block buffer that doubles as the 16-word rolling message schedule
// bytes are written in place, each padding block is laid down in a single write, rounds shift the line
// depends on sha256md_pkg
`timescale 1ns / 1ps

module sha256md_sched (
	input  logic                   clk,
	input  sha256md_pkg::sch_ctrl_t ctl,
	input  logic [5:0]             pos,
	input  logic [7:0]             data_byte,
	input  logic [63:0]            len,
	output sha256md_pkg::word_t    w_cur
);
	import sha256md_pkg::*;

	word_t w_q [16];
	word_t w_new;

	// next schedule word, W[t+16] from the four taps
	assign w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	assign w_cur = w_q[0];

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int j = 0; j < 15; j++) begin
				w_q[j] <= w_q[j + 1];
			end
			w_q[15] <= w_new;
		end else begin
			for (int b = 0; b < 64; b++) begin
				if (ctl.wr_byte && pos == 6'(b)) begin
					w_q[b / 4][31 - 8 * (b % 4) -: 8] <= data_byte;
				end else if (ctl.pad_first) begin
					if (pos == 6'(b)) begin
						w_q[b / 4][31 - 8 * (b % 4) -: 8] <= PadMark;
					end else if (pos < 6'(b)) begin
						// length only fits when the mark landed before it
						if (b >= 56 && pos < LenPos) begin
							w_q[b / 4][31 - 8 * (b % 4) -: 8] <= len[8 * (63 - b) +: 8];
						end else begin
							w_q[b / 4][31 - 8 * (b % 4) -: 8] <= 8'h00;
						end
					end
				end else if (ctl.pad_second) begin
					if (b >= 56) begin
						w_q[b / 4][31 - 8 * (b % 4) -: 8] <= len[8 * (63 - b) +: 8];
					end else begin
						w_q[b / 4][31 - 8 * (b % 4) -: 8] <= 8'h00;
					end
				end
			end
		end
	end

endmodule

// File: hw/rtl/sha256md_round.sv
// sha256md_round: hash words, working variables and the shared compression round
// one round per step, feed-forward add of all eight words on acc
// depends on sha256md_pkg
`timescale 1ns / 1ps

module sha256md_round (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha256md_pkg::rnd_ctrl_t ctl,
	input  logic [5:0]              round,
	input  sha256md_pkg::word_t     w,
	input  logic [2:0]              rd_idx,
	output sha256md_pkg::word_t     rd_word
);
	import sha256md_pkg::*;

	word_t hash_q [8];
	word_t v_q [8];
	word_t t1;
	word_t t2;
	word_t choose;
	word_t major;

	assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign major = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose + RoundK[round] + w;
	assign t2 = big_sigma0(v_q[0]) + major;
	assign rd_word = hash_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) begin
				hash_q[j] <= HashIv[j];
			end
		end else if (ctl.init) begin
			for (int j = 0; j < 8; j++) begin
				hash_q[j] <= HashIv[j];
			end
		end else if (ctl.acc) begin
			for (int j = 0; j < 8; j++) begin
				hash_q[j] <= hash_q[j] + v_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int j = 0; j < 8; j++) begin
				v_q[j] <= hash_q[j];
			end
		end else if (ctl.step) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

endmodule

// File: hw/rtl/sha256_message_digest_top.sv
// sha256_message_digest_top: sha-256 byte-stream hasher, sequencer and handshakes
// instantiates sha256md_sched and sha256md_round; depends on sha256md_pkg
`timescale 1ns / 1ps

// sha-256 over a byte stream. each input beat carries a command: absorb adds
// data_byte to the message, finish pads the message and returns the digest as
// eight output beats (word 0 first, last_word on word 7) and then starts a new
// message, restart drops the message in progress; command code 3 is ignored.
// an absorb beat leaves in_ready high, except the 64th byte of a block,
// which starts a compression: the rounds on the single shared round unit,
// then the feed-forward add, after which in_ready returns. a finish runs
// one compression when the buffered tail is under 56 bytes and two when a
// second padding block is needed, then the eight digest beats are offered
// one per cycle at whatever pace out_ready allows. in_ready is low during
// compression and while the digest is being read out. the 64-byte block
// buffer is the schedule shift line itself, so no copy is made before the
// rounds. the bit length is kept as a block count and the byte fill,
// wrapping modulo 2^64.

module sha256_message_digest_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha256md_pkg::*;

	state_t    state_q;
	state_t    state_nxt;
	logic [5:0]  round_q;     // round counter, wraps to 0 after the last round
	logic [5:0]  fill_q;      // bytes in the current block
	logic [54:0] blocks_q;    // compressed blocks, i.e. bit length above bit 8
	logic        fin_q;       // current compression belongs to a finish
	logic        second_q;    // finish still owes the length-only block
	logic [2:0]  idx_q;       // digest word being offered

	logic        in_beat;
	logic        out_beat;
	logic        is_absorb;
	logic        is_finish;
	logic        is_restart;
	logic [63:0] msg_len;

	sch_ctrl_t   sch_ctl;
	rnd_ctrl_t   rnd_ctl;
	word_t       w_cur;
	word_t       hash_word;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_beat = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	assign is_absorb = in_beat && (cmd == CMD_ABSORB);
	assign is_finish = in_beat && (cmd == CMD_FINISH);
	assign is_restart = in_beat && (cmd == CMD_RESTART);

	// total message bits: whole blocks times 512 plus buffered bytes times 8
	assign msg_len = {blocks_q, fill_q, 3'b000};

	assign digest_word = hash_word;
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if ((is_absorb && fill_q == 6'd63) || is_finish) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == 6'd63) begin
					state_nxt = ST_ACC;
				end
			end
			ST_ACC: begin
				priority if (fin_q && second_q) begin
					state_nxt = ST_PAD2;
				end else if (fin_q) begin
					state_nxt = ST_EMIT;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_PAD2: begin
				state_nxt = ST_ROUND;
			end
			ST_EMIT: begin
				if (out_beat && idx_q == 3'd7) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// datapath controls
	always_comb begin
		sch_ctl = '0;
		rnd_ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				sch_ctl.wr_byte = is_absorb;
				sch_ctl.pad_first = is_finish;
				rnd_ctl.init = is_restart;
				rnd_ctl.load = (is_absorb && fill_q == 6'd63) || is_finish;
			end
			ST_ROUND: begin
				sch_ctl.shift = 1'b1;
				rnd_ctl.step = 1'b1;
			end
			ST_ACC: begin
				rnd_ctl.acc = 1'b1;
			end
			ST_PAD2: begin
				sch_ctl.pad_second = 1'b1;
				rnd_ctl.load = 1'b1;
			end
			ST_EMIT: begin
				rnd_ctl.init = out_beat && (idx_q == 3'd7);
			end
			default: begin
				sch_ctl = '0;
				rnd_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			fill_q <= '0;
			blocks_q <= '0;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (is_absorb) begin
				// fill wraps to 0 on the 64th byte
				fill_q <= fill_q + 6'd1;
				if (fill_q == 6'd63) begin
					blocks_q <= blocks_q + 55'd1;
				end
			end
			if (is_restart || rnd_ctl.init) begin
				fill_q <= '0;
				blocks_q <= '0;
			end
			if (is_finish) begin
				fin_q <= 1'b1;
				second_q <= (fill_q >= LenPos);
			end
			if (state_q == ST_PAD2) begin
				second_q <= 1'b0;
			end
			if (out_beat) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					fin_q <= 1'b0;
				end
			end
		end
	end

	sha256md_sched u_sched (
		.clk       (clk),
		.ctl       (sch_ctl),
		.pos       (fill_q),
		.data_byte (data_byte),
		.len       (msg_len),
		.w_cur     (w_cur)
	);

	sha256md_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rnd_ctl),
		.round   (round_q),
		.w       (w_cur),
		.rd_idx  (idx_q),
		.rd_word (hash_word)
	);

	// the input and output sides never open together
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid high together");

	// every compression starts at round zero
	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && $past(state_q) != ST_ROUND) |-> (round_q == 6'd0))
		else $error("compression entered at a nonzero round");

	// digest readout starts at word zero
	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (word_index == 3'd0))
		else $error("digest readout did not start at word 0");

	// after the last digest beat the block is ready for a new message
	a_last_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> (in_ready && fill_q == 6'd0))
		else $error("block not restarted after last digest beat");

endmodule

// File: test/sha256_message_digest_top_tb.sv
// sha256_message_digest_top_tb: self-checking testbench of the sha-256 byte-stream hasher
// drives absorb/finish/restart beats, predicts each digest and checks every output beat
// depends on sha256md_pkg and sha256_message_digest_top
`timescale 1ns / 1ps

module sha256_message_digest_top_tb;

	import sha256md_pkg::*;

	// command code 3 has no name in the package; the block ignores it
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int IdleLimit = 4000;   // cycles with no beat on either side
	localparam int LongHold = 400;     // one long receiver hold-off
	localparam int RandBeats = 134;    // random beats that do real work
	localparam int RandDigests = 3;    // random part also runs to this many digests
	localparam int TailCycles = 200;   // longer than a two-block finish

	localparam logic [31:0] KTable [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		logic [1:0] op;
		logic [7:0] value;
		int         gap;     // idle cycles after this beat is taken
		bit         drain;   // hold this beat until every digest word is back
	} pending_beat_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_ABSORB;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	pending_beat_t beat_queue [$];
	digest_beat_t  digest_due [$];
	pending_beat_t head_beat;

	// running hash of the message in flight
	logic [31:0] hash_h [8];
	logic [7:0]  msg_buf [64];
	int unsigned buf_fill;
	logic [63:0] msg_bits;

	int send_gap = 0;
	int stall_left = 0;
	int rx_cycle = 0;
	int idle_cycles = 0;
	bit long_hold_done = 0;
	int fail_count = 0;
	int beats_taken = 0;
	int words_checked = 0;
	int digests_checked = 0;
	int pad_one = 0;
	int pad_two = 0;
	int directed_beats = 0;
	int longest_msg = 0;

	sha256_message_digest_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void new_message();
		for (int j = 0; j < 8; j++)
			hash_h[j] = InitHash[j];
		buf_fill = 0;
		msg_bits = '0;
	endfunction

	// full 64-word schedule, then the 64 rounds and the feed-forward add
	function automatic void compress_buffer();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int j = 0; j < 16; j++)
			w[j] = {msg_buf[4*j], msg_buf[4*j+1], msg_buf[4*j+2], msg_buf[4*j+3]};
		for (int j = 16; j < 64; j++) begin
			s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
			s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
			w[j] = w[j-16] + s0 + w[j-7] + s1;
		end
		a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
		e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
		for (int r = 0; r < 64; r++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ KTable[r] + w[r];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
		hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
	endfunction

	// advance the predicted hash by one taken input beat
	function automatic void hash_input_beat(input logic [1:0] op, input logic [7:0] value);
		logic [63:0] total;
		int pos;
		digest_beat_t due;
		case (op)
			CMD_ABSORB: begin
				msg_buf[buf_fill] = value;
				buf_fill++;
				if (buf_fill == 64) begin
					compress_buffer();
					msg_bits += 64'd512;
					buf_fill = 0;
				end
			end
			CMD_RESTART: new_message();
			CMD_FINISH: begin
				total = msg_bits + (64'(buf_fill) << 3);
				pos = buf_fill;
				msg_buf[pos] = 8'h80;
				pos++;
				// no room left for the length: an extra padding block goes first
				if (pos > 56) begin
					while (pos < 64) begin
						msg_buf[pos] = 8'h00;
						pos++;
					end
					compress_buffer();
					pos = 0;
					pad_two++;
				end else begin
					pad_one++;
				end
				while (pos < 56) begin
					msg_buf[pos] = 8'h00;
					pos++;
				end
				for (int j = 0; j < 8; j++)
					msg_buf[63 - j] = total[8*j +: 8];
				compress_buffer();
				for (int j = 0; j < 8; j++) begin
					due.word = hash_h[j];
					due.idx = 3'(j);
					due.last = (j == 7);
					digest_due.push_back(due);
				end
				new_message();
			end
			default: ;   // unused code: no state change
		endcase
	endfunction

	initial begin
		for (int j = 0; j < 64; j++)
			msg_buf[j] = 8'h00;
		new_message();
	end

	// ---------------------------------------------------------------- driver

	// valid stays up with a fixed payload until the beat is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_ABSORB;
			data_byte <= 8'h00;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				hash_input_beat(cmd, data_byte);
				beats_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (beat_queue.size() != 0
						&& !(beat_queue[0].drain && digest_due.size() != 0)) begin
					head_beat = beat_queue.pop_front();
					in_valid <= 1'b1;
					cmd <= head_beat.op;
					data_byte <= head_beat.value;
					send_gap <= head_beat.gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("mismatch in %s, digest %0d word %0d: expected %h, got %h",
			field, digests_checked, words_checked, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			rx_cycle++;
			if (out_valid && out_ready) begin
				if (digest_due.size() == 0) begin
					report_mismatch("unexpected beat", 32'h0, digest_word);
				end else begin
					automatic digest_beat_t due = digest_due.pop_front();
					if (digest_word !== due.word)
						report_mismatch("digest_word", due.word, digest_word);
					if (word_index !== due.idx)
						report_mismatch("word_index", 32'(due.idx), 32'(word_index));
					if (last_word !== due.last)
						report_mismatch("last_word", 32'(due.last), 32'(last_word));
				end
				words_checked++;
				if (last_word)
					digests_checked++;
			end
			// after two digests the receiver goes away for a long stretch so the
			// block backs up and stalls the sender
			if (words_checked == 16 && !long_hold_done) begin
				long_hold_done = 1;
				stall_left <= LongHold;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if ((rx_cycle / 256) % 4 == 1) begin
				out_ready <= 1'b1;   // calm stretch, always ready
			end else begin
				automatic int r = $urandom_range(0, 99);
				if (r < 3) begin
					stall_left <= $urandom_range(20, 60);
					out_ready <= 1'b0;
				end else begin
					out_ready <= (r >= 25);
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("timeout: no beat for %0d cycles", IdleLimit);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void add_beat(input logic [1:0] op, input logic [7:0] value,
			input bit drain, input bit calm);
		pending_beat_t pb;
		pb.op = op;
		pb.value = value;
		pb.gap = pick_gap(calm);
		pb.drain = drain;
		beat_queue.push_back(pb);
	endfunction

	initial begin
		int rand_beats;
		int rand_digests;
		int len;
		int r;
		bit calm;
		bit drain;

		// directed: empty message, ignored code, byte extremes, "abc", restart
		add_beat(CMD_FINISH, 8'hff, 0, 0);
		add_beat(CMD_UNUSED, 8'ha5, 0, 0);
		add_beat(CMD_ABSORB, 8'h00, 0, 0);
		add_beat(CMD_ABSORB, 8'hff, 0, 0);
		add_beat(CMD_FINISH, 8'h00, 0, 0);
		add_beat(CMD_ABSORB, 8'h61, 0, 1);
		add_beat(CMD_ABSORB, 8'h62, 0, 1);
		add_beat(CMD_ABSORB, 8'h63, 0, 1);
		add_beat(CMD_FINISH, 8'h5a, 0, 1);
		add_beat(CMD_ABSORB, 8'h5a, 0, 0);
		add_beat(CMD_ABSORB, 8'h00, 0, 0);
		add_beat(CMD_RESTART, 8'hc3, 0, 0);
		add_beat(CMD_UNUSED, 8'hff, 0, 0);
		add_beat(CMD_ABSORB, 8'h33, 0, 0);
		add_beat(CMD_FINISH, 8'h00, 0, 0);
		// sender waits here for the whole digest before going on
		add_beat(CMD_FINISH, 8'h01, 1, 0);
		directed_beats = beat_queue.size();

		// random messages, weighted toward the lengths around the padding limits
		rand_beats = 0;
		rand_digests = 0;
		while (rand_beats < RandBeats || rand_digests < RandDigests) begin
			r = $urandom_range(0, 9);
			case (r)
				0, 1, 2, 3: len = $urandom_range(0, 10);
				4: len = 55;
				5: len = 56;
				6: len = 63;
				7: len = 64;
				8: len = $urandom_range(119, 121);
				default: len = $urandom_range(11, 130);
			endcase
			// keep the whole run near its beat budget
			if (len > RandBeats - rand_beats)
				len = (rand_beats < RandBeats) ? RandBeats - rand_beats : 0;
			if (len > longest_msg)
				longest_msg = len;
			calm = ($urandom_range(0, 3) == 0);
			drain = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) == 0) begin
				add_beat(CMD_RESTART, 8'($urandom), drain, calm);
				rand_beats++;
				drain = 0;
			end
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(0, 19) == 0)
					add_beat(CMD_UNUSED, 8'($urandom), 0, calm);
				add_beat(CMD_ABSORB, 8'($urandom), drain && j == 0, calm);
				rand_beats++;
			end
			// mostly finished; now and then the message is thrown away instead
			if ($urandom_range(0, 9) == 0) begin
				add_beat(CMD_RESTART, 8'($urandom), drain && len == 0, calm);
			end else begin
				add_beat(CMD_FINISH, 8'($urandom), drain && len == 0, calm);
				rand_digests++;
			end
			rand_beats++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (beat_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("covered %0d input beats (%0d directed), %0d digests, %0d digest words",
			beats_taken, directed_beats, digests_checked, words_checked);
		$display("single-block padding %0d times, two-block padding %0d times, %s %0d bytes",
			pad_one, pad_two, "messages up to", longest_msg);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
